/* rtl/core/serial_loaded_bank_mapper_macros.svh */
// Assertion macros used by the checker file of the bank mapper.
`ifndef SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_MACROS_SVH

// Property that must hold in the cycle it is sampled.
`define SLBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define SLBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/slbm_pkg.sv */
// Package with the types and constants of the bank mapper.
`default_nettype none

package slbm_pkg;

  localparam int unsigned PRG_ADDR_BITS_DEF = 18;
  localparam int unsigned CHR_ADDR_BITS_DEF = 17;
  localparam int unsigned MEM_ADDR_W        = 18;
  localparam int unsigned CFG_ADDR_W        = 4;
  localparam int unsigned CFG_DATA_W        = 32;

  typedef enum logic [1:0] {
    CMD_PRG_RD = 2'd0,
    CMD_PRG_WR = 2'd1,
    CMD_CHR_RD = 2'd2,
    CMD_CHR_WR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_WRAM    = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    REG_PRG_BANK_COUNT = 2'd0,
    REG_CHR_BANK_COUNT = 2'd1,
    REG_CHR_IS_RAM     = 2'd2,
    REG_UNUSED         = 2'd3
  } reg_idx_e;

  // Serial register selected by address bits 14:13 of the fifth write.
  typedef enum logic [1:0] {
    SEL_CONTROL  = 2'd0,
    SEL_CHR_LOW  = 2'd1,
    SEL_CHR_HIGH = 2'd2,
    SEL_PRG_BANK = 2'd3
  } load_sel_e;

  localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
  localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;
  localparam logic [4:0] SHIFT_EMPTY        = 5'h10;

  typedef struct packed {
    logic [4:0] prg_bank_count;
    logic [5:0] chr_bank_count;
    logic       chr_is_ram;
  } slbm_cfg_t;

  typedef struct packed {
    logic [3:0] prg_bank;
    logic [4:0] chr_bank_low;
    logic [4:0] chr_bank_high;
    logic [1:0] mirror_mode;
    logic [1:0] prg_mode;
    logic       chr_mode;
  } slbm_state_t;

  typedef struct packed {
    target_e                 target;
    logic [MEM_ADDR_W-1:0]   mem_address;
    logic                    write_enable;
    logic [7:0]              write_data;
  } slbm_result_t;

endpackage

`default_nettype wire

/* rtl/core/serial_loaded_bank_mapper.sv */
// Top level of the serial-loaded cartridge bank mapper.
`default_nettype none

// Translates one bus request per clock cycle. A request is captured in an input register, then
// decoded, translated and applied to the serial loader, and its result is captured in the output
// register; a stalled result holds the request in the input register. Throughput is one request
// every cycle; only a stalled result holds the input side. The user must write the size registers
// over the APB port only while no request is in flight; the block itself does not enforce this.

module serial_loaded_bank_mapper
  import slbm_pkg::*;
#(
  parameter int unsigned PRG_ADDR_BITS = PRG_ADDR_BITS_DEF,
  parameter int unsigned CHR_ADDR_BITS = CHR_ADDR_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            command_i,
  input  wire logic [15:0]           address_i,
  input  wire logic [7:0]            data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [1:0]                 target_o,
  output logic [MEM_ADDR_W-1:0]      mem_address_o,
  output logic                       write_enable_o,
  output logic [7:0]                 write_data_o,
  output logic [1:0]                 mirroring_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  logic         in_valid_q;
  logic [1:0]   cmd_q;
  logic [15:0]  addr_q;
  logic [7:0]   data_q;
  logic         out_valid_q;
  slbm_result_t res_q;
  logic [1:0]   mirror_q;
  logic         advance;
  logic         fire;
  logic         in_accept;
  slbm_cfg_t    cfg;
  slbm_state_t  state;
  slbm_result_t res_d;
  logic [1:0]   mirror_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  slbm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slbm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .command_i     (cmd_q),
    .address_i     (addr_q),
    .data_i        (data_q),
    .state_o       (state),
    .mirror_next_o (mirror_d)
  );

  slbm_xlate #(
    .PRG_ADDR_BITS (PRG_ADDR_BITS),
    .CHR_ADDR_BITS (CHR_ADDR_BITS)
  ) u_xlate (
    .command_i (cmd_q),
    .address_i (addr_q),
    .data_i    (data_q),
    .state_i   (state),
    .cfg_i     (cfg),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      data_q <= data_i;
    end
    if (fire) begin
      res_q    <= res_d;
      mirror_q <= mirror_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign target_o       = res_q.target;
  assign mem_address_o  = res_q.mem_address;
  assign write_enable_o = res_q.write_enable;
  assign write_data_o   = res_q.write_data;
  assign mirroring_o    = mirror_q;

endmodule

`default_nettype wire

/* rtl/core/slbm_cfg.sv */
// APB register block holding the memory size configuration.
`default_nettype none

module slbm_cfg
  import slbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output slbm_cfg_t                  cfg_o
);

  slbm_cfg_t cfg_q, cfg_d;
  reg_idx_e  idx;
  logic      wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_PRG_BANK_COUNT: cfg_d.prg_bank_count = pwdata[4:0];
        REG_CHR_BANK_COUNT: cfg_d.chr_bank_count = pwdata[5:0];
        REG_CHR_IS_RAM:     cfg_d.chr_is_ram     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PRG_BANK_COUNT: prdata = CFG_DATA_W'(cfg_q.prg_bank_count);
      REG_CHR_BANK_COUNT: prdata = CFG_DATA_W'(cfg_q.chr_bank_count);
      REG_CHR_IS_RAM:     prdata = CFG_DATA_W'(cfg_q.chr_is_ram);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prg_bank_count <= 5'd16;
      cfg_q.chr_bank_count <= 6'd2;
      cfg_q.chr_is_ram     <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/slbm_ctrl.sv */
// Serial loader and bank registers of the mapper.
`default_nettype none

module slbm_ctrl
  import slbm_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  output slbm_state_t      state_o,
  output logic [1:0]       mirror_next_o
);

  slbm_state_t state_q, state_d;
  logic [4:0]  shift_q, shift_d;
  logic [4:0]  shift_next;
  logic        serial_wr;

  assign serial_wr  = fire_i && (cmd_e'(command_i) == CMD_PRG_WR) && address_i[15];
  assign shift_next = {data_i[0], shift_q[4:1]};

  always_comb begin
    state_d = state_q;
    shift_d = shift_q;
    if (serial_wr) begin
      if (data_i[7]) begin
        shift_d = SHIFT_EMPTY;
      end else if (shift_q[0]) begin
        shift_d = SHIFT_EMPTY;
        case (load_sel_e'(address_i[14:13]))
          SEL_PRG_BANK: state_d.prg_bank      = shift_next[3:0];
          SEL_CHR_HIGH: state_d.chr_bank_high = shift_next;
          SEL_CHR_LOW:  state_d.chr_bank_low  = shift_next;
          default: begin
            state_d.mirror_mode = shift_next[1:0];
            state_d.prg_mode    = shift_next[3:2];
            state_d.chr_mode    = shift_next[4];
          end
        endcase
      end else begin
        shift_d = shift_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q               <= SHIFT_EMPTY;
      state_q.prg_bank      <= '0;
      state_q.chr_bank_low  <= '0;
      state_q.chr_bank_high <= '0;
      state_q.mirror_mode   <= '0;
      state_q.prg_mode      <= PRG_MODE_FIX_LAST;
      state_q.chr_mode      <= 1'b0;
    end else begin
      shift_q <= shift_d;
      state_q <= state_d;
    end
  end

  assign state_o       = state_q;
  assign mirror_next_o = state_d.mirror_mode;

endmodule

`default_nettype wire

/* rtl/core/slbm_xlate.sv */
// Address decode and bank translation of one bus request.
`default_nettype none

module slbm_xlate
  import slbm_pkg::*;
#(
  parameter int unsigned PRG_ADDR_BITS = PRG_ADDR_BITS_DEF,
  parameter int unsigned CHR_ADDR_BITS = CHR_ADDR_BITS_DEF
) (
  input  wire logic [1:0]  command_i,
  input  wire logic [15:0] address_i,
  input  wire logic [7:0]  data_i,
  input  slbm_state_t      state_i,
  input  slbm_cfg_t        cfg_i,
  output slbm_result_t     result_o
);

  logic [18:0]              prg_mask;
  logic [18:0]              prg_base;
  logic [18:0]              prg_sum;
  logic [PRG_ADDR_BITS-1:0] prg_addr;
  logic [17:0]              chr_mask;
  logic [4:0]               chr_bank;
  logic [16:0]              chr_raw;
  logic [CHR_ADDR_BITS-1:0] chr_addr;
  logic                     prg_half;
  logic                     chr_half;
  logic                     in_wram;

  assign prg_half = address_i[14];
  assign chr_half = address_i[12];
  assign in_wram  = (address_i[15:13] == 3'b011);

  assign prg_mask = {cfg_i.prg_bank_count, 14'd0} - 19'd1;
  assign chr_mask = {cfg_i.chr_bank_count, 12'd0} - 18'd1;

  always_comb begin
    case (state_i.prg_mode)
      PRG_MODE_FIX_FIRST:
        prg_base = prg_half ? {1'b0, state_i.prg_bank, 14'd0} : 19'd0;
      PRG_MODE_FIX_LAST:
        prg_base = prg_half ? {cfg_i.prg_bank_count - 5'd1, 14'd0}
                            : {1'b0, state_i.prg_bank, 14'd0};
      default:
        prg_base = prg_half ? {1'b0, state_i.prg_bank | 4'h1, 14'd0}
                            : {1'b0, state_i.prg_bank & 4'hE, 14'd0};
    endcase
  end

  assign prg_sum  = prg_base + {5'd0, address_i[13:0]};
  assign prg_addr = prg_sum[PRG_ADDR_BITS-1:0] & prg_mask[PRG_ADDR_BITS-1:0];

  always_comb begin
    if (!state_i.chr_mode) begin
      chr_bank = chr_half ? (state_i.chr_bank_low | 5'h01)
                          : (state_i.chr_bank_low & 5'h1E);
    end else begin
      chr_bank = chr_half ? state_i.chr_bank_high : state_i.chr_bank_low;
    end
  end

  assign chr_raw  = {chr_bank, address_i[11:0]};
  assign chr_addr = chr_raw[CHR_ADDR_BITS-1:0] & chr_mask[CHR_ADDR_BITS-1:0];

  always_comb begin
    result_o.target       = TGT_NONE;
    result_o.mem_address  = '0;
    result_o.write_enable = 1'b0;
    case (cmd_e'(command_i))
      CMD_PRG_RD: begin
        if (address_i[15]) begin
          result_o.target      = TGT_PRG_ROM;
          result_o.mem_address = MEM_ADDR_W'(prg_addr);
        end else if (in_wram) begin
          result_o.target      = TGT_WRAM;
          result_o.mem_address = MEM_ADDR_W'(address_i[12:0]);
        end
      end
      CMD_PRG_WR: begin
        if (!address_i[15] && in_wram) begin
          result_o.target       = TGT_WRAM;
          result_o.mem_address  = MEM_ADDR_W'(address_i[12:0]);
          result_o.write_enable = 1'b1;
        end
      end
      CMD_CHR_RD: begin
        result_o.target      = TGT_CHR;
        result_o.mem_address = MEM_ADDR_W'(chr_addr);
      end
      default: begin
        if (cfg_i.chr_is_ram) begin
          result_o.target       = TGT_CHR;
          result_o.mem_address  = MEM_ADDR_W'(chr_addr);
          result_o.write_enable = 1'b1;
        end
      end
    endcase
    result_o.write_data = result_o.write_enable ? data_i : 8'd0;
  end

endmodule

`default_nettype wire

/* rtl/core/slbm_checker.sv */
// Port-level assertions of the bank mapper and their binding to the top level.
`default_nettype none

`include "serial_loaded_bank_mapper_macros.svh"

module slbm_checker
  import slbm_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [1:0]            target_o,
  input wire logic [MEM_ADDR_W-1:0] mem_address_o,
  input wire logic                  write_enable_o,
  input wire logic [7:0]            write_data_o
);

  `SLBM_ASSERT(a_we_target, !(out_valid_o && write_enable_o) || target_o == TGT_WRAM || target_o == TGT_CHR, "A write request targets neither work RAM nor pattern memory.")
  `SLBM_ASSERT(a_wdata_zero, !(out_valid_o && !write_enable_o) || write_data_o == 8'd0, "Write data is non-zero on a request that writes nothing.")
  `SLBM_ASSERT(a_none_addr, !(out_valid_o && target_o == TGT_NONE) || (mem_address_o == '0 && !write_enable_o), "A request without target carries an address or a write.")
  `SLBM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(mem_address_o) && $stable(target_o), "A stalled result changed.")

endmodule

bind serial_loaded_bank_mapper slbm_checker u_slbm_checker (.*);

`default_nettype wire
